### hdl/rgba16_pixel_format_packer_unit_defines.svh
// assertion helpers for the pixel packer
`ifndef RGBA16_PIXEL_FORMAT_PACKER_UNIT_DEFINES_SVH
`define RGBA16_PIXEL_FORMAT_PACKER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RGBAPK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RGBAPK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rgbapk_pkg.sv
package rgbapk_pkg;

    // gray weights, sum of weights is 2^GRAY_SHIFT
    localparam logic [31:0] GRAY_WR    = 32'd6969;
    localparam logic [31:0] GRAY_WG    = 32'd23434;
    localparam logic [31:0] GRAY_WB    = 32'd2365;
    localparam int          GRAY_SHIFT = 15;

    // configuration port
    localparam int   CFG_IDX_W  = 1;
    localparam int   CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE   = 1'b1;

    // job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FMT_GRAY       = 2'd0,
        FMT_GRAY_ALPHA = 2'd1,
        FMT_RGB        = 2'd2,
        FMT_RGBA       = 2'd3
    } t_format;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       pixel_done;
    } t_out;

    // one classified pixel: channel values in send order
    typedef struct packed {
        logic [3:0][15:0] chan;
        logic [1:0]       last_chan;
        logic             wide;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // floor(v / 257): v >> 8 overshoots by at most one
    function automatic logic [7:0] div257(input logic [15:0] v);
        logic [7:0]  q;
        logic [16:0] prod;
        q    = v[15:8];
        prod = {1'b0, q, 8'h00} + 17'(q);
        if (prod > 17'(v)) begin
            q = q - 8'd1;
        end
        return q;
    endfunction

endpackage

### hdl/rgbapk_front.sv
module rgbapk_front
    import rgbapk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_pixel       i_pixel,
    input  t_format      i_format,
    input  logic         i_wide,
    output logic         o_push_valid,
    output t_job         o_push_job,
    input  t_fifo_status i_fifo_status
);

    logic        r_valid;
    logic [31:0] r_prod_r;
    logic [31:0] r_prod_g;
    logic [31:0] r_prod_b;
    t_pixel      r_pixel;
    t_format     r_format;
    logic        r_wide;

    logic        s_advance;
    logic        s_accept;
    logic [31:0] s_sum;
    logic [15:0] s_gray;

    assign s_advance  = !r_valid || !i_fifo_status.full;
    assign s_accept   = i_in_valid && s_advance;
    assign o_in_ready = s_advance;

    // stage register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_advance) begin
            r_valid <= i_in_valid;
        end
    end

    // stage register: weighted products and pixel
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_prod_r <= 32'(i_pixel.red) * GRAY_WR;
            r_prod_g <= 32'(i_pixel.green) * GRAY_WG;
            r_prod_b <= 32'(i_pixel.blue) * GRAY_WB;
            r_pixel  <= i_pixel;
            r_format <= i_format;
            r_wide   <= i_wide;
        end
    end

    // gray value, fits in 16 bits
    assign s_sum  = r_prod_r + r_prod_g + r_prod_b;
    assign s_gray = s_sum[GRAY_SHIFT +: 16];

    // classify into channel list
    always_comb begin
        o_push_job      = '0;
        o_push_job.wide = r_wide;
        unique case (r_format)
            FMT_GRAY: begin
                o_push_job.chan[0]   = s_gray;
                o_push_job.last_chan = 2'd0;
            end
            FMT_GRAY_ALPHA: begin
                o_push_job.chan[0]   = s_gray;
                o_push_job.chan[1]   = r_pixel.alpha;
                o_push_job.last_chan = 2'd1;
            end
            FMT_RGB: begin
                o_push_job.chan[0]   = r_pixel.red;
                o_push_job.chan[1]   = r_pixel.green;
                o_push_job.chan[2]   = r_pixel.blue;
                o_push_job.last_chan = 2'd2;
            end
            FMT_RGBA: begin
                o_push_job.chan[0]   = r_pixel.red;
                o_push_job.chan[1]   = r_pixel.green;
                o_push_job.chan[2]   = r_pixel.blue;
                o_push_job.chan[3]   = r_pixel.alpha;
                o_push_job.last_chan = 2'd3;
            end
            default: begin
                o_push_job.last_chan = 2'd0;
            end
        endcase
    end

    assign o_push_valid = r_valid && !i_fifo_status.full;

endmodule

### hdl/rgbapk_fifo.sv
module rgbapk_fifo
    import rgbapk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_job         i_push_job,
    input  logic         i_pop,
    output t_job         o_head,
    output t_fifo_status o_status
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### hdl/rgbapk_back.sv
module rgbapk_back
    import rgbapk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_job         i_head,
    input  t_fifo_status i_fifo_status,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_out         o_out
);

    logic [1:0]  r_chan_idx;
    logic        r_low_byte;
    logic        r_out_valid;
    t_out        r_out;

    logic        s_load;
    logic        s_last;
    logic [15:0] s_chan;
    logic [7:0]  s_byte;

    assign s_load = !i_fifo_status.empty && (!r_out_valid || i_out_ready);
    assign s_chan = i_head.chan[r_chan_idx];
    assign s_last = (r_chan_idx == i_head.last_chan) && (!i_head.wide || r_low_byte);

    // byte selection, narrow channels scaled down by 257
    always_comb begin
        if (i_head.wide) begin
            s_byte = r_low_byte ? s_chan[7:0] : s_chan[15:8];
        end else begin
            s_byte = div257(s_chan);
        end
    end

    // position within the current pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_idx <= '0;
            r_low_byte <= 1'b0;
        end else if (s_load) begin
            if (s_last) begin
                r_chan_idx <= '0;
                r_low_byte <= 1'b0;
            end else if (i_head.wide && !r_low_byte) begin
                r_low_byte <= 1'b1;
            end else begin
                r_chan_idx <= r_chan_idx + 2'd1;
                r_low_byte <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out.out_byte   <= s_byte;
            r_out.pixel_done <= s_last;
        end
    end

    assign o_pop       = s_load && s_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hdl/rgba16_pixel_format_packer_unit.sv
// Packs one RGBA pixel of 16-bit channels into a byte stream in the configured layout
// (gray, gray with alpha, RGB or RGBA; 16-bit channels as big-endian byte pairs or
// 8-bit channels as value / 257), one byte per output transaction with pixel_done on
// the last byte of each pixel. A pixel has from one byte (8-bit gray) to eight (16-bit
// RGBA): the single output byte port sets the sustained rate, and pixels are accepted
// every cycle while the four-entry job queue has room.
// The first byte of a pixel is registered in the gray product stage, then written to the
// job queue, then loaded into the output register, where it sits until it is taken.
// The user must write configuration only while the block is idle; the block does not enforce it.
`include "rgba16_pixel_format_packer_unit_defines.svh"

module rgba16_pixel_format_packer_unit
    import rgbapk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pixel                i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    t_format      r_format;
    logic         r_wide;

    logic         s_push;
    t_job         s_push_job;
    logic         s_pop;
    t_job         s_head;
    t_fifo_status s_fifo_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGBA;
            r_wide   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_format <= t_format'(i_cfg_data[1:0]);
                CFG_WIDE:   r_wide   <= i_cfg_data[0];
                default:    r_wide   <= r_wide;
            endcase
        end
    end

    // front: accept and classify
    rgbapk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_format      (r_format),
        .i_wide        (r_wide),
        .o_push_valid  (s_push),
        .o_push_job    (s_push_job),
        .i_fifo_status (s_fifo_status)
    );

    // job queue
    rgbapk_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s_push),
        .i_push_job (s_push_job),
        .i_pop      (s_pop),
        .o_head     (s_head),
        .o_status   (s_fifo_status)
    );

    // back: byte serialiser
    rgbapk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (s_head),
        .i_fifo_status (s_fifo_status),
        .o_pop         (s_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out)
    );

    // checks
    `RGBAPK_ASSERT_NOW(a_queue_status, 1'b1,
        !(s_fifo_status.full && s_fifo_status.empty), "queue full and empty at once")
    `RGBAPK_ASSERT_NEXT(a_no_phantom_byte,
        s_fifo_status.empty && (!o_out_valid || i_out_ready), !o_out_valid,
        "byte shown with no queued job")
    `RGBAPK_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "output changed while stalled")
    `RGBAPK_ASSERT_NOW(a_pop_not_empty, s_pop, !s_fifo_status.empty, "pop from empty queue")

endmodule
